@@ src/vgrt_pkg.sv @@
// Package for the voxel grid ray traversal block.
// Holds item structs, status and opcode codes, and the sequencer state type.
// No dependencies.
package vgrt_pkg;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    localparam logic [1:0] CONTENT_AIR    = 2'd0;
    localparam logic [1:0] CONTENT_ABSENT = 2'd2;

    localparam logic [1:0] CFG_BOUND_X = 2'd0;
    localparam logic [1:0] CFG_BOUND_Y = 2'd1;
    localparam logic [1:0] CFG_BOUND_Z = 2'd2;

    localparam logic [14:0] BOUND_RESET = 15'h7FFF;
    localparam logic [31:0] T_MAX       = 32'hFFFF_FFFF;
    localparam logic [19:0] SPACING_NUM = 20'h01000;

    typedef enum logic [2:0] {
        STAT_QUERY   = 3'd0,
        STAT_SOLID   = 3'd1,
        STAT_ABSENT  = 3'd2,
        STAT_REACH   = 3'd3,
        STAT_BOUND   = 3'd4,
        STAT_NO_DIR  = 3'd5,
        STAT_IGNORED = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_SQRT,
        S_DLOAD,
        S_DRUN,
        S_FIN,
        S_EMIT
    } fsm_t;

    typedef struct packed {
        logic               opcode;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic signed [23:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [15:0]        ray_reach;
        logic [1:0]         voxel_content;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] voxel_x;
        logic signed [15:0] voxel_y;
        logic signed [15:0] voxel_z;
    } out_item_t;

endpackage

@@ src/voxel_grid_ray_traversal.sv @@
// Top level of the voxel grid ray traversal block.
// Depends on vgrt_pkg for item structs, codes and the sequencer state type.
//
// Usage: an input item with opcode start brings a ray (origin, direction,
// reach). The block answers with one item: status query and the voxel that
// holds the origin, or a stop status (bound, no direction). Each following
// answer item carries the content of the queried voxel; the block replies
// with the next voxel to query or with a stop status (solid, absent, reach
// exceeded, bound). An answer with no ray in flight is answered as ignored.
// Work per item: an answer item is stepped in the accept cycle, and its result
// is then loaded into the output register. A start item runs three squares
// through one shared multiplier, a 16-step square root, and up to seven
// quotients from one restoring divider that produces one bit per cycle.
// A zero direction skips the squares, the root and the divider.
// One item is in work at a time; in_stall is high until its result has moved
// into the output register, which holds it while out_stall is high.
// Reset clears the sequencer and step state and sets the world bounds to 32767.
// The bound registers are written through cfg_we, cfg_index and cfg_data.
module voxel_grid_ray_traversal
    import vgrt_pkg::*;
#(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int NW = 20 + T_FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam int AW = (COORD_BITS + 1 > 16) ? COORD_BITS + 1 : 16;
    localparam logic [CW-1:0] SQR_LAST  = CW'(2);
    localparam logic [CW-1:0] SQRT_LAST = CW'(15);
    localparam logic [CW-1:0] DIV_LAST  = CW'(NW - 1);
    localparam logic [2:0]    JOB_REACH = 3'd6;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    fsm_t               state_reg, state_next;
    coord_t             cur_reg [3];
    coord_t             cur_next [3];
    logic signed [1:0]  sign_reg [3];
    logic signed [1:0]  sign_next [3];
    logic [31:0]        nb_reg [3];
    logic [31:0]        nb_next [3];
    logic [31:0]        sp_reg [3];
    logic [31:0]        sp_next [3];
    logic [31:0]        reach_lim_reg, reach_lim_next;
    logic               active_reg, active_next;
    logic [14:0]        bound_reg [3];
    logic [14:0]        bound_next [3];
    logic signed [15:0] dir_reg [3];
    logic signed [15:0] dir_next [3];
    logic [7:0]         frac_reg [3];
    logic [7:0]         frac_next [3];
    logic [15:0]        reach_reg, reach_next;
    logic               zero_dir_reg, zero_dir_next;
    logic [31:0]        sq_reg, sq_next;
    logic [31:0]        sqop_reg, sqop_next;
    logic [18:0]        rem_reg, rem_next;
    logic [15:0]        root_reg, root_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [2:0]         job_reg, job_next;
    logic [NW-1:0]      dq_reg, dq_next;
    logic [16:0]        drem_reg, drem_next;
    logic [16:0]        dvs_reg, dvs_next;
    status_t            status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    logic               in_acc;
    logic signed [15:0] dsel;
    logic signed [31:0] prod;
    logic [18:0]        rem_sh, sq_trial;
    logic [16:0]        d_sh;
    logic [17:0]        d_diff;
    logic               d_ge;
    logic [63:0]        q64;
    logic [31:0]        q_sat;
    logic [1:0]         ax;
    logic [1:0]         jax;
    logic signed [16:0] d17;
    logic [8:0]         num;
    logic [19:0]        xnum;
    logic [31:0]        t_sel;
    logic [32:0]        t_add;

    function automatic logic in_world(coord_t c, logic [14:0] b);
        logic [AW-1:0] a;
        a = c[COORD_BITS-1] ? AW'(-(AW'(c))) : AW'(c);
        return a < AW'(b);
    endfunction

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign dsel  = dir_reg[cnt_reg[1:0]];
    assign prod  = dsel * dsel;

    assign rem_sh   = {rem_reg[16:0], sqop_reg[31:30]};
    assign sq_trial = {1'b0, root_reg, 2'b01};

    assign d_sh   = {drem_reg[15:0], dq_reg[NW-1]};
    assign d_diff = {1'b0, d_sh} - {1'b0, dvs_reg};
    assign d_ge   = !d_diff[17];
    assign q64    = 64'({dq_reg[NW-2:0], d_ge});
    assign q_sat  = (|q64[63:32]) ? T_MAX : q64[31:0];

    assign jax  = job_reg[2:1];
    assign d17  = 17'(dir_reg[jax]);
    assign num  = (dir_reg[jax] > 16'sd0) ? (9'd256 - {1'b0, frac_reg[jax]})
                                          : {1'b0, frac_reg[jax]};
    assign xnum = job_reg[0] ? SPACING_NUM : {7'd0, num, 4'd0};

    assign ax = (nb_reg[0] < nb_reg[1]) ? ((nb_reg[0] < nb_reg[2]) ? 2'd0 : 2'd2)
                                        : ((nb_reg[1] < nb_reg[2]) ? 2'd1 : 2'd2);
    assign t_sel = nb_reg[ax];
    assign t_add = {1'b0, t_sel} + {1'b0, sp_reg[ax]};

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        sign_next      = sign_reg;
        nb_next        = nb_reg;
        sp_next        = sp_reg;
        reach_lim_next = reach_lim_reg;
        active_next    = active_reg;
        bound_next     = bound_reg;
        dir_next       = dir_reg;
        frac_next      = frac_reg;
        reach_next     = reach_reg;
        zero_dir_next  = zero_dir_reg;
        sq_next        = sq_reg;
        sqop_next      = sqop_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        cnt_next       = cnt_reg;
        job_next       = job_reg;
        dq_next        = dq_reg;
        drem_next      = drem_reg;
        dvs_next       = dvs_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOUND_X: bound_next[0] = cfg_data;
                CFG_BOUND_Y: bound_next[1] = cfg_data;
                CFG_BOUND_Z: bound_next[2] = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_item.opcode == OP_START)
                begin
                    cur_next[0]  = COORD_BITS'(in_item.origin_x >>> 8);
                    cur_next[1]  = COORD_BITS'(in_item.origin_y >>> 8);
                    cur_next[2]  = COORD_BITS'(in_item.origin_z >>> 8);
                    frac_next[0] = in_item.origin_x[7:0];
                    frac_next[1] = in_item.origin_y[7:0];
                    frac_next[2] = in_item.origin_z[7:0];
                    dir_next[0]  = in_item.dir_x;
                    dir_next[1]  = in_item.dir_y;
                    dir_next[2]  = in_item.dir_z;
                    for (int i = 0; i < 3; i++)
                    begin
                        sign_next[i] = (dir_next[i] > 16'sd0) ? 2'sd1 :
                                       (dir_next[i] < 16'sd0) ? -2'sd1 : 2'sd0;
                    end
                    reach_next    = in_item.ray_reach;
                    active_next   = 1'b0;
                    zero_dir_next = (in_item.dir_x == 16'sd0) &&
                                    (in_item.dir_y == 16'sd0) &&
                                    (in_item.dir_z == 16'sd0);
                    sq_next  = '0;
                    cnt_next = '0;
                    job_next = '0;
                    state_next = zero_dir_next ? S_DLOAD : S_SQR;
                end
                else if (in_acc)
                begin
                    state_next = S_EMIT;
                    if (!active_reg)
                    begin
                        status_next = STAT_IGNORED;
                    end
                    else if (in_item.voxel_content == CONTENT_ABSENT)
                    begin
                        status_next = STAT_ABSENT;
                        active_next = 1'b0;
                    end
                    else if (in_item.voxel_content != CONTENT_AIR)
                    begin
                        status_next = STAT_SOLID;
                        active_next = 1'b0;
                    end
                    else
                    begin
                        cur_next[ax] = cur_reg[ax] + COORD_BITS'(sign_reg[ax]);
                        if (t_sel > reach_lim_reg)
                        begin
                            status_next = STAT_REACH;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            nb_next[ax] = t_add[32] ? T_MAX : t_add[31:0];
                            if (in_world(cur_next[0], bound_reg[0]) &&
                                in_world(cur_next[1], bound_reg[1]) &&
                                in_world(cur_next[2], bound_reg[2]))
                            begin
                                status_next = STAT_QUERY;
                            end
                            else
                            begin
                                status_next = STAT_BOUND;
                                active_next = 1'b0;
                            end
                        end
                    end
                end
            end
            S_SQR:
            begin
                sq_next  = sq_reg + $unsigned(prod);
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == SQR_LAST)
                begin
                    sqop_next  = sq_next;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                sqop_next = {sqop_reg[29:0], 2'b00};
                if (rem_sh >= sq_trial)
                begin
                    rem_next  = rem_sh - sq_trial;
                    root_next = {root_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                cnt_next  = '0;
                drem_next = '0;
                if (job_reg == JOB_REACH)
                begin
                    if (zero_dir_reg)
                    begin
                        reach_lim_next = '0;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        dq_next    = {{reach_reg, 4'd0}, {T_FRAC_BITS{1'b0}}};
                        dvs_next   = {1'b0, root_reg};
                        state_next = S_DRUN;
                    end
                end
                else if (dir_reg[jax] == 16'sd0)
                begin
                    if (job_reg[0])
                    begin
                        sp_next[jax] = T_MAX;
                    end
                    else
                    begin
                        nb_next[jax] = T_MAX;
                    end
                    job_next = job_reg + 3'd1;
                end
                else
                begin
                    dq_next    = {xnum, {T_FRAC_BITS{1'b0}}};
                    dvs_next   = d17[16] ? -d17 : d17;
                    state_next = S_DRUN;
                end
            end
            S_DRUN:
            begin
                dq_next   = {dq_reg[NW-2:0], d_ge};
                drem_next = d_ge ? d_diff[16:0] : d_sh;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    if (job_reg == JOB_REACH)
                    begin
                        reach_lim_next = q_sat;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        if (job_reg[0])
                        begin
                            sp_next[jax] = q_sat;
                        end
                        else
                        begin
                            nb_next[jax] = q_sat;
                        end
                        job_next   = job_reg + 3'd1;
                        state_next = S_DLOAD;
                    end
                end
            end
            S_FIN:
            begin
                state_next = S_EMIT;
                if (zero_dir_reg)
                begin
                    status_next = STAT_NO_DIR;
                end
                else if (in_world(cur_reg[0], bound_reg[0]) &&
                         in_world(cur_reg[1], bound_reg[1]) &&
                         in_world(cur_reg[2], bound_reg[2]))
                begin
                    status_next = STAT_QUERY;
                    active_next = 1'b1;
                end
                else
                begin
                    status_next = STAT_BOUND;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_next.status  = status_reg;
                    out_next.voxel_x = 16'(cur_reg[0]);
                    out_next.voxel_y = 16'(cur_reg[1]);
                    out_next.voxel_z = 16'(cur_reg[2]);
                    state_next       = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            reach_lim_reg <= '0;
            zero_dir_reg  <= 1'b0;
            cnt_reg       <= '0;
            job_reg       <= '0;
            status_reg    <= STAT_QUERY;
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i]   <= '0;
                sign_reg[i]  <= '0;
                nb_reg[i]    <= '0;
                sp_reg[i]    <= '0;
                bound_reg[i] <= BOUND_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            reach_lim_reg <= reach_lim_next;
            zero_dir_reg  <= zero_dir_next;
            cnt_reg       <= cnt_next;
            job_reg       <= job_next;
            status_reg    <= status_next;
            cur_reg       <= cur_next;
            sign_reg      <= sign_next;
            nb_reg        <= nb_next;
            sp_reg        <= sp_next;
            bound_reg     <= bound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg   <= dir_next;
        frac_reg  <= frac_next;
        reach_reg <= reach_next;
        sq_reg    <= sq_next;
        sqop_reg  <= sqop_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        dq_reg    <= dq_next;
        drem_reg  <= drem_next;
        dvs_reg   <= dvs_next;
        out_reg   <= out_next;
    end

`ifndef SYNTH
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_item.opcode == OP_START |=> state_reg != S_IDLE)
        else $error("start item did not enter setup");

    a_active_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> state_reg == S_EMIT && status_reg == STAT_QUERY)
        else $error("ray became active without a query result");

    a_spacing_x: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && sign_reg[0] != 2'sd0 |-> sp_reg[0] != 32'd0)
        else $error("zero spacing on a moving axis");

    a_flat_axis: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && sign_reg[1] == 2'sd0 |-> nb_reg[1] == T_MAX)
        else $error("boundary moved on an axis with no direction");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the voxel grid ray traversal block.
// Depends on vgrt_pkg; predicts every result item and checks it field by field
// while both handshake sides idle and stall at random.
module tb;
    import vgrt_pkg::*;

    localparam int IN_BITS = $bits(in_item_t);

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    voxel_grid_ray_traversal DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    in_item_t  pending_items[$];
    out_item_t expected_voxels[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        in_took = 0;
    bit        out_took = 0;
    bit        burst = 0;
    bit        hold_request = 0;
    int        send_gap = 0;
    int        recv_wait = 0;
    int        hold_count = 0;

    // Traversal state kept by the predictor.
    logic [14:0]        bnd_x = BOUND_RESET, bnd_y = BOUND_RESET, bnd_z = BOUND_RESET;
    logic signed [15:0] vx = 0, vy = 0, vz = 0;
    int                 sgn_x = 0, sgn_y = 0, sgn_z = 0;
    logic [31:0]        tb_x = 0, tb_y = 0, tb_z = 0;
    logic [31:0]        dt_x = 0, dt_y = 0, dt_z = 0;
    logic [31:0]        t_reach = 0;
    bit                 in_flight = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] clip32(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? T_MAX : v[31:0];
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void axis_setup(input logic signed [23:0] o,
                                       input logic signed [15:0] d,
                                       output int sg, output logic [31:0] nb,
                                       output logic [31:0] sp);
        longint unsigned f, ad, num;
        f = 64'(o[7:0]);
        if (d == 0)
        begin
            sg = 0;
            nb = T_MAX;
            sp = T_MAX;
        end
        else
        begin
            ad = (d < 0) ? -longint'(d) : longint'(d);
            sg = (d > 0) ? 1 : -1;
            num = (d > 0) ? 256 - f : f;
            nb = clip32(((num * 16) << 16) / ad);
            sp = clip32((64'd4096 << 16) / ad);
        end
    endfunction

    function automatic bit in_world();
        int ax, ay, az;
        ax = (vx < 0) ? -int'(vx) : int'(vx);
        ay = (vy < 0) ? -int'(vy) : int'(vy);
        az = (vz < 0) ? -int'(vz) : int'(vz);
        return ax < int'(bnd_x) && ay < int'(bnd_y) && az < int'(bnd_z);
    endfunction

    function automatic out_item_t voxel_at(status_t st);
        out_item_t r;
        r.status = st;
        r.voxel_x = vx;
        r.voxel_y = vy;
        r.voxel_z = vz;
        return r;
    endfunction

    function automatic out_item_t trace_step(in_item_t it);
        longint sq;
        longint unsigned mag;
        logic [31:0] t;
        int axis;
        if (it.opcode == OP_START)
        begin
            vx = it.origin_x[23:8];
            vy = it.origin_y[23:8];
            vz = it.origin_z[23:8];
            axis_setup(it.origin_x, it.dir_x, sgn_x, tb_x, dt_x);
            axis_setup(it.origin_y, it.dir_y, sgn_y, tb_y, dt_y);
            axis_setup(it.origin_z, it.dir_z, sgn_z, tb_z, dt_z);
            in_flight = 0;
            if (it.dir_x == 0 && it.dir_y == 0 && it.dir_z == 0)
            begin
                t_reach = 0;
                return voxel_at(STAT_NO_DIR);
            end
            sq = longint'(it.dir_x) * it.dir_x + longint'(it.dir_y) * it.dir_y
                 + longint'(it.dir_z) * it.dir_z;
            mag = root64(sq);
            if (mag == 0) mag = 1;
            t_reach = clip32(((longint'(it.ray_reach) * 16) << 16) / mag);
            if (!in_world()) return voxel_at(STAT_BOUND);
            in_flight = 1;
            return voxel_at(STAT_QUERY);
        end
        if (!in_flight) return voxel_at(STAT_IGNORED);
        if (it.voxel_content == CONTENT_ABSENT)
        begin
            in_flight = 0;
            return voxel_at(STAT_ABSENT);
        end
        if (it.voxel_content != CONTENT_AIR)
        begin
            in_flight = 0;
            return voxel_at(STAT_SOLID);
        end
        if (tb_x < tb_y) axis = (tb_x < tb_z) ? 0 : 2;
        else axis = (tb_y < tb_z) ? 1 : 2;
        if (axis == 0)
        begin
            vx = 16'(vx + sgn_x);
            t = tb_x;
            if (t <= t_reach) tb_x = clip32(longint'(tb_x) + dt_x);
        end
        else if (axis == 1)
        begin
            vy = 16'(vy + sgn_y);
            t = tb_y;
            if (t <= t_reach) tb_y = clip32(longint'(tb_y) + dt_y);
        end
        else
        begin
            vz = 16'(vz + sgn_z);
            t = tb_z;
            if (t <= t_reach) tb_z = clip32(longint'(tb_z) + dt_z);
        end
        if (t > t_reach)
        begin
            in_flight = 0;
            return voxel_at(STAT_REACH);
        end
        if (!in_world())
        begin
            in_flight = 0;
            return voxel_at(STAT_BOUND);
        end
        return voxel_at(STAT_QUERY);
    endfunction

    task automatic queue_item(in_item_t it);
        pending_items.push_back(it);
        expected_voxels.push_back(trace_step(it));
    endtask

    function automatic in_item_t make_start(logic signed [23:0] ox, logic signed [23:0] oy,
                                            logic signed [23:0] oz, logic signed [15:0] dx,
                                            logic signed [15:0] dy, logic signed [15:0] dz,
                                            logic [15:0] reach);
        in_item_t it;
        it = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.opcode = OP_START;
        it.origin_x = ox;
        it.origin_y = oy;
        it.origin_z = oz;
        it.dir_x = dx;
        it.dir_y = dy;
        it.dir_z = dz;
        it.ray_reach = reach;
        return it;
    endfunction

    function automatic in_item_t make_answer(logic [1:0] content);
        in_item_t it;
        it = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.opcode = OP_ANSWER;
        it.voxel_content = content;
        return it;
    endfunction

    function automatic logic signed [23:0] rand_origin(logic [14:0] b);
        if ($urandom_range(0, 5) == 0) return 24'($urandom);
        return 24'($signed($urandom_range(0, 2 * b * 256 + 511)) - int'(b) * 256 - 256);
    endfunction

    function automatic logic signed [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'sd0;
            1: return 16'($signed($urandom_range(0, 255)) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_ray();
        logic [15:0] reach;
        int steps;
        reach = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
        queue_item(make_start(rand_origin(bnd_x), rand_origin(bnd_y), rand_origin(bnd_z),
                              rand_dir(), rand_dir(), rand_dir(), reach));
        steps = 0;
        while (in_flight)
        begin
            if (steps >= 40 || $urandom_range(0, 19) == 0)
                queue_item(make_answer(2'($urandom_range(1, 3))));
            else
                queue_item(make_answer(CONTENT_AIR));
            steps++;
        end
        if ($urandom_range(0, 9) == 0) queue_item(make_answer(2'($urandom)));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_voxels.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_bounds(logic [14:0] bx, logic [14:0] by, logic [14:0] bz);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= CFG_BOUND_X;
        cfg_data <= bx;
        @(negedge clk);
        cfg_index <= CFG_BOUND_Y;
        cfg_data <= by;
        @(negedge clk);
        cfg_index <= CFG_BOUND_Z;
        cfg_data <= bz;
        @(negedge clk);
        cfg_we <= 0;
        bnd_x = bx;
        bnd_y = by;
        bnd_z = bz;
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        errors++;
    endtask

    // Stimulus and phases.
    initial
    begin
        int count;
        in_valid = 0;
        in_item = '0;
        out_stall = 0;
        cfg_we = 0;
        cfg_index = CFG_BOUND_X;
        cfg_data = '0;
        rst_n = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        queue_item(make_answer(CONTENT_AIR));
        queue_item(make_start(24'h000180, 24'h000080, 24'hFFFF00,
                              16'sd0, 16'sd0, 16'sd0, 16'hFFFF));
        queue_item(make_start(24'h7FFFFF, 24'sd0, 24'sd0,
                              16'sh7FFF, 16'sd0, 16'sd0, 16'h0000));
        queue_item(make_start(24'h800000, 24'sd0, 24'sd0,
                              -16'sh8000, 16'sd0, 16'sd0, 16'hFFFF));
        queue_item(make_start(24'h000080, 24'hFFFF40, 24'h000010,
                              16'sh1000, 16'sh0800, -16'sh0400, 16'h0800));
        queue_item(make_answer(CONTENT_AIR));
        queue_item(make_answer(CONTENT_AIR));
        queue_item(make_answer(2'd3));
        queue_item(make_answer(CONTENT_AIR));
        queue_item(make_start(24'sd0, 24'sd0, 24'sd0,
                              16'sh0001, 16'sd0, 16'sd0, 16'hFFFF));
        queue_item(make_answer(CONTENT_AIR));
        queue_item(make_start(24'h000100, 24'h000100, 24'h000100,
                              -16'sh8000, -16'sh8000, -16'sh8000, 16'h0400));
        queue_item(make_answer(CONTENT_AIR));
        queue_item(make_answer(CONTENT_ABSENT));
        queue_item(make_start(24'sd0, 24'sd0, 24'sd0,
                              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000));
        queue_item(make_answer(CONTENT_AIR));
        queue_item(make_start(24'sd0, 24'sd0, 24'sd0,
                              16'sh1000, 16'sd0, 16'sd0, 16'h0100));
        queue_item(make_answer(2'd1));
        hold_request = 1;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                case (ph)
                    1: write_bounds(15'd1, 15'd1, 15'd1);
                    2: write_bounds(15'h7FFF, 15'd1, 15'h7FFF);
                    3: write_bounds(15'($urandom_range(2, 12)), 15'($urandom_range(2, 12)),
                                    15'($urandom_range(2, 12)));
                    4: write_bounds(15'($urandom_range(1, 32767)),
                                    15'($urandom_range(1, 32767)),
                                    15'($urandom_range(1, 32767)));
                    default: write_bounds(15'h7FFF, 15'h7FFF, 15'h7FFF);
                endcase
            end
            count = pending_items.size();
            while (pending_items.size() < count + 240) random_ray();
        end
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Input driver.
    always @(negedge clk)
    begin
        bit took;
        if (rst_n)
        begin
            took = in_took;
            if (in_took)
            begin
                void'(pending_items.pop_front());
                if ($urandom_range(0, 15) == 0) burst = ~burst;
                send_gap = burst ? 0 : $urandom_range(0, 9);
                in_took = 0;
            end
            if (!in_valid || took)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 0;
                end
                else if (pending_items.size() != 0)
                begin
                    in_valid <= 1;
                    in_item <= pending_items[0];
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // Output receiver with random stalls and one long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
            begin
                recv_wait = burst ? 0 : $urandom_range(0, 9);
                out_took = 0;
            end
            if (hold_request)
            begin
                hold_count = 600;
                hold_request = 0;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                out_stall <= 1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1;
            end
            else
                out_stall <= 0;
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (in_valid && !in_stall)
            begin
                in_took = 1;
                idle_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                out_took = 1;
                idle_cycles = 0;
                if (expected_voxels.size() == 0)
                begin
                    $display("unexpected result item, status %0d", out_item.status);
                    errors++;
                end
                else
                begin
                    want = expected_voxels.pop_front();
                    if (out_item.status !== want.status)
                        report_mismatch("status", out_item.status, want.status);
                    if (out_item.voxel_x !== want.voxel_x)
                        report_mismatch("voxel_x", out_item.voxel_x, want.voxel_x);
                    if (out_item.voxel_y !== want.voxel_y)
                        report_mismatch("voxel_y", out_item.voxel_y, want.voxel_y);
                    if (out_item.voxel_z !== want.voxel_z)
                        report_mismatch("voxel_z", out_item.voxel_z, want.voxel_z);
                end
            end
            if (idle_cycles >= 5000)
            begin
                $display("watchdog timeout");
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

@@ voxel_grid_ray_traversal.f @@
src/vgrt_pkg.sv
src/voxel_grid_ray_traversal.sv
tb/tb.sv
